// ===== hw/rtl/sk4_pkg.sv =====
`default_nettype none
package sk4_pkg;

  localparam int unsigned NumSteps = 4;
  localparam int unsigned StepIdxW = 2;
  localparam int unsigned WordW    = 16;
  localparam int unsigned OpW      = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // step opcodes
  localparam logic [OpW-1:0] OpSwap     = 8'h05;
  localparam logic [OpW-1:0] OpAndLe    = 8'h37;
  localparam logic [OpW-1:0] OpOrLe     = 8'h52;
  localparam logic [OpW-1:0] OpAddLe    = 8'h75;
  localparam logic [OpW-1:0] OpSubLe    = 8'hf8;
  localparam logic [OpW-1:0] OpAddBe    = 8'h14;
  localparam logic [OpW-1:0] OpNegCmp   = 8'h2a;
  localparam logic [OpW-1:0] OpRotL     = 8'h4c;
  localparam logic [OpW-1:0] OpRotR     = 8'h6b;
  localparam logic [OpW-1:0] OpSwapAdd  = 8'h7e;
  localparam logic [OpW-1:0] OpSubBe    = 8'h98;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCount = 8'd8;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] arg;
  } step_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] value;
  } stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sk4_if.sv =====
`default_nettype none
interface sk4_seed_if;
  logic        valid;
  logic        ready;
  logic [15:0] seed_value;
  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

interface sk4_key_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_value;
  modport source (output valid, output key_value, input ready);
  modport sink   (input valid, input key_value, output ready);
endinterface

interface sk4_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sk4_cfg_regs.sv =====
`default_nettype none
module sk4_cfg_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [sk4_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [sk4_pkg::CfgDataW-1:0] wr_data_i,
  output sk4_pkg::step_cfg_t            step_cfg_o [sk4_pkg::NumSteps]
);
  import sk4_pkg::*;

  step_cfg_t cfg_q [NumSteps];
  logic [StepIdxW-1:0] sel;

  // even index writes the opcode, odd index the argument
  assign sel = wr_idx_i[StepIdxW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSteps; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (wr_en_i && (wr_idx_i < RegCount)) begin
      if (wr_idx_i[0]) begin
        cfg_q[sel].arg <= wr_data_i;
      end else begin
        cfg_q[sel].op <= wr_data_i[OpW-1:0];
      end
    end
  end

  assign step_cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sk4_cell.sv =====
`default_nettype none
module sk4_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  sk4_pkg::step_cfg_t      cfg_i,
  input  sk4_pkg::stage_t         in_i,
  output logic                    in_ready_o,
  output sk4_pkg::stage_t         out_o,
  input  wire logic               out_ready_i
);
  import sk4_pkg::*;

  logic [7:0]       arg_a, arg_b;
  logic [WordW-1:0] le, be, v, swapped, result;
  logic [2*WordW-1:0] rotl_w, rotr_w;
  logic             valid_q, valid_d;
  logic [WordW-1:0] value_q, value_d;

  assign arg_a   = cfg_i.arg[15:8];
  assign arg_b   = cfg_i.arg[7:0];
  assign be      = cfg_i.arg;
  assign le      = {arg_b, arg_a};
  assign v       = in_i.value;
  assign swapped = {v[7:0], v[15:8]};
  // rotate through a doubled word
  assign rotl_w  = {v, v} << arg_a[3:0];
  assign rotr_w  = {v, v} >> arg_b[3:0];

  always_comb begin
    unique case (cfg_i.op)
      OpSwap:    result = swapped;
      OpAndLe:   result = v & le;
      OpOrLe:    result = v | le;
      OpAddLe:   result = v + le;
      OpSubLe:   result = v - le;
      OpAddBe:   result = v + be;
      OpNegCmp:  result = ~v + {{(WordW-1){1'b0}}, (arg_a < arg_b)};
      OpRotL:    result = rotl_w[2*WordW-1:WordW];
      OpRotR:    result = rotr_w[WordW-1:0];
      OpSwapAdd: result = swapped + ((arg_b > arg_a) ? le : be);
      OpSubBe:   result = v - be;
      default:   result = v;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (in_ready_o) begin
      valid_d = in_i.valid;
      if (in_i.valid) begin
        value_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.value = value_q;

endmodule
`default_nettype wire

// ===== hw/rtl/seed_to_key_four_op_transform.sv =====
`default_nettype none
// Four-step seed-to-key transform.
// seed_i takes one 16-bit seed word; key_o gives one 16-bit key word per seed,
// in order. cfg_i writes the step registers: index 2k is the opcode of step
// k+1 (low 8 data bits kept), index 2k+1 its argument; other indexes are
// ignored. cfg_i is always ready and should be written only while no seed is
// in flight.
// The datapath is a row of four cells, one per step, each with its own
// output register; a seed passes through the four in turn to key valid.
// A new seed can be taken every cycle unless a key_o stall filled the row.
// When key_o stalls, the last cell holds its key and the cells behind it
// keep filling until every cell is full; seed_i ready then drops until the
// key is taken. Ready propagates back through the row in the same cycle.
// Reset clears every cell's valid flag and sets all step registers to 0,
// so each step starts as a pass-through.
module seed_to_key_four_op_transform (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sk4_seed_if.sink       seed_i,
  sk4_key_if.source      key_o,
  sk4_cfg_if.sink        cfg_i
);
  import sk4_pkg::*;

  step_cfg_t step_cfg [NumSteps];
  stage_t    stage_in [NumSteps+1];
  logic      stage_rdy [NumSteps+1];

  assign cfg_i.ready = 1'b1;

  sk4_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_idx_i   (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .step_cfg_o (step_cfg)
  );

  assign stage_in[0].valid = seed_i.valid;
  assign stage_in[0].value = seed_i.seed_value;
  assign seed_i.ready      = stage_rdy[0];

  for (genvar k = 0; k < NumSteps; k++) begin : g_cell
    sk4_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (step_cfg[k]),
      .in_i        (stage_in[k]),
      .in_ready_o  (stage_rdy[k]),
      .out_o       (stage_in[k+1]),
      .out_ready_i (stage_rdy[k+1])
    );
  end

  assign stage_rdy[NumSteps] = key_o.ready;
  assign key_o.valid         = stage_in[NumSteps].valid;
  assign key_o.key_value     = stage_in[NumSteps].value;

  // an accepted seed always lands in the first cell
  a_seed_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_i.valid && seed_i.ready |=> stage_in[1].valid)
    else $error("accepted seed did not enter first cell");

  // an empty row must take a seed
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_in[1].valid && !stage_in[2].valid && !stage_in[3].valid &&
    !stage_in[4].valid |-> seed_i.ready)
    else $error("empty row not ready for a seed");

  // a full row under a stalled key must block the seed side
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_in[1].valid && stage_in[2].valid && stage_in[3].valid &&
    stage_in[4].valid && !key_o.ready |-> !seed_i.ready)
    else $error("seed accepted while row full and key stalled");

endmodule
`default_nettype wire

// ===== bench/sk4_key_checker.sv =====
`timescale 1ns / 1ps
module sk4_key_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         seed_valid_i,
  input  logic                         seed_ready_i,
  input  logic [sk4_pkg::WordW-1:0]    seed_value_i,
  input  logic                         key_valid_i,
  input  logic                         key_ready_i,
  input  logic [sk4_pkg::WordW-1:0]    key_value_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [sk4_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sk4_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           errors_o,
  output int                           keys_due_o,
  output int                           keys_checked_o
);
  import sk4_pkg::*;

  step_cfg_t        step_regs [NumSteps];
  logic [WordW-1:0] keys_due [$];
  logic [WordW-1:0] want;
  int               errors;
  int               keys_checked;

  task automatic report_error(input string msg);
    // keep the log readable when the whole datapath is off
    if (errors < 100) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [WordW-1:0] rot_left(input logic [WordW-1:0] v,
                                                input logic [3:0] n);
    logic [2*WordW-1:0] both;
    both = {v, v} << n;
    return both[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] rot_right(input logic [WordW-1:0] v,
                                                 input logic [3:0] n);
    logic [2*WordW-1:0] both;
    both = {v, v} >> n;
    return both[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] transform_step(input step_cfg_t s,
                                                      input logic [WordW-1:0] v);
    logic [7:0]       hi_byte;
    logic [7:0]       lo_byte;
    logic [WordW-1:0] little;
    logic [WordW-1:0] swapped;
    hi_byte = s.arg[15:8];
    lo_byte = s.arg[7:0];
    little  = {lo_byte, hi_byte};
    swapped = {v[7:0], v[15:8]};
    case (s.op)
      OpSwap:    return swapped;
      OpAndLe:   return v & little;
      OpOrLe:    return v | little;
      OpAddLe:   return v + little;
      OpSubLe:   return v - little;
      OpAddBe:   return v + s.arg;
      OpNegCmp:  return (hi_byte < lo_byte) ? (~v + 16'd1) : ~v;
      OpRotL:    return rot_left(v, hi_byte[3:0]);
      OpRotR:    return rot_right(v, lo_byte[3:0]);
      OpSwapAdd: return (lo_byte > hi_byte) ? (swapped + little) : (swapped + s.arg);
      OpSubBe:   return v - s.arg;
      default:   return v;
    endcase
  endfunction

  function automatic logic [WordW-1:0] key_for_seed(input logic [WordW-1:0] seed);
    logic [WordW-1:0] v;
    v = seed;
    for (int k = 0; k < NumSteps; k++) v = transform_step(step_regs[k], v);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (step_regs[k]) step_regs[k] <= '0;
      keys_due.delete();
      errors = 0;
      keys_checked = 0;
    end else begin
      // even index is an opcode, odd index its argument, the rest is dropped
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < RegCount) begin
        if (cfg_index_i[0]) begin
          step_regs[cfg_index_i[StepIdxW:1]].arg <= cfg_data_i;
        end else begin
          step_regs[cfg_index_i[StepIdxW:1]].op <= cfg_data_i[OpW-1:0];
        end
      end
      if (key_valid_i && key_ready_i) begin
        if (keys_due.size() == 0) begin
          report_error($sformatf("key word %h with no seed outstanding", key_value_i));
        end else begin
          want = keys_due.pop_front();
          if (key_value_i !== want) begin
            report_error($sformatf("key_value %h, predicted %h", key_value_i, want));
          end
          keys_checked++;
        end
      end
      if (seed_valid_i && seed_ready_i) keys_due.push_back(key_for_seed(seed_value_i));
    end
    errors_o       <= errors;
    keys_due_o     <= keys_due.size();
    keys_checked_o <= keys_checked;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sk4_pkg::*;

  localparam logic [CfgIdxW-1:0] RegStep1Op  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStep1Arg = 8'd1;
  localparam logic [CfgIdxW-1:0] RegStep2Op  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegStep2Arg = 8'd3;
  localparam logic [CfgIdxW-1:0] RegStep3Op  = 8'd4;
  localparam logic [CfgIdxW-1:0] RegStep3Arg = 8'd5;
  localparam logic [CfgIdxW-1:0] RegStep4Op  = 8'd6;
  localparam logic [CfgIdxW-1:0] RegStep4Arg = 8'd7;

  localparam logic [OpW-1:0] KnownOps [11] = '{OpSwap, OpAndLe, OpOrLe, OpAddLe, OpSubLe,
                                               OpAddBe, OpNegCmp, OpRotL, OpRotR,
                                               OpSwapAdd, OpSubBe};

  localparam int StallLimit   = 1000;
  localparam int RandomRounds = 15;
  localparam int SeedsPerRound = 40;

  logic      clk_i;
  logic      rst_ni;
  bit        calm;
  step_cfg_t plan [NumSteps];
  int        seeds_sent;
  int        programs_loaded;
  int        stall_cycles;
  int        errors;
  int        keys_due;
  int        keys_checked;

  sk4_seed_if seed_ch ();
  sk4_key_if  key_ch ();
  sk4_cfg_if  cfg_ch ();

  seed_to_key_four_op_transform i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_ch),
    .key_o  (key_ch),
    .cfg_i  (cfg_ch)
  );

  sk4_key_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_valid_i   (seed_ch.valid),
    .seed_ready_i   (seed_ch.ready),
    .seed_value_i   (seed_ch.seed_value),
    .key_valid_i    (key_ch.valid),
    .key_ready_i    (key_ch.ready),
    .key_value_i    (key_ch.key_value),
    .cfg_valid_i    (cfg_ch.valid),
    .cfg_ready_i    (cfg_ch.ready),
    .cfg_index_i    (cfg_ch.index),
    .cfg_data_i     (cfg_ch.data),
    .errors_o       (errors),
    .keys_due_o     (keys_due),
    .keys_checked_o (keys_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) key_ch.ready <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk_i) begin
    if ((seed_ch.valid && seed_ch.ready) || (key_ch.valid && key_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    if ($urandom_range(9) == 0) return OpW'($urandom);
    return KnownOps[$urandom_range(10)];
  endfunction

  function automatic logic [WordW-1:0] pick_arg();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(5))
      0:       return {b, b};
      1:       return 16'hffff;
      2:       return 16'h0000;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_seed();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return WordW'($urandom);
    endcase
  endfunction

  task automatic send_seed(input logic [WordW-1:0] seed);
    while (take_break()) begin
      seed_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    seed_ch.valid      <= 1'b1;
    seed_ch.seed_value <= seed;
    do @(posedge clk_i); while (!seed_ch.ready);
    seeds_sent++;
  endtask

  // valid stays high across back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // opcode writes carry junk in the upper byte, which the block must drop
  task automatic load_program();
    write_reg(RegStep1Op, {8'($urandom), plan[0].op});
    write_reg(RegStep1Arg, plan[0].arg);
    write_reg(RegStep2Op, {8'($urandom), plan[1].op});
    write_reg(RegStep2Arg, plan[1].arg);
    write_reg(RegStep3Op, {8'($urandom), plan[2].op});
    write_reg(RegStep3Arg, plan[2].arg);
    write_reg(RegStep4Op, {8'($urandom), plan[3].op});
    write_reg(RegStep4Arg, plan[3].arg);
    write_reg(CfgIdxW'($urandom_range(255, RegCount)), CfgDataW'($urandom));
    cfg_ch.valid <= 1'b0;
    programs_loaded++;
  endtask

  task automatic drain();
    seed_ch.valid <= 1'b0;
    do @(posedge clk_i); while (keys_due != 0);
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    calm               = 1'b0;
    seeds_sent         = 0;
    programs_loaded    = 0;
    stall_cycles       = 0;
    seed_ch.valid      = 1'b0;
    seed_ch.seed_value = '0;
    key_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset every step has opcode zero and passes the value through
    send_seed(16'h0000);
    send_seed(16'hffff);
    drain();

    plan[0] = '{OpSwap, 16'h0000};
    plan[1] = '{OpAndLe, 16'h1234};
    plan[2] = '{OpOrLe, 16'h00ff};
    plan[3] = '{OpAddLe, 16'hffff};
    load_program();
    send_seed(16'hffff);
    send_seed(16'h0001);
    send_seed(16'h8000);
    drain();

    // negate when A < B, complement when A >= B, equal bytes included
    plan[0] = '{OpSubLe, 16'h0102};
    plan[1] = '{OpAddBe, 16'hfffe};
    plan[2] = '{OpNegCmp, 16'h0102};
    plan[3] = '{OpNegCmp, 16'h0505};
    load_program();
    send_seed(16'h0000);
    send_seed(16'h7fff);
    send_seed(16'h8000);
    drain();

    // rotate amounts wrap mod 16, swap-add with B > A
    plan[0] = '{OpRotL, 16'h1300};
    plan[1] = '{OpRotR, 16'h0010};
    plan[2] = '{OpSwapAdd, 16'h01ff};
    plan[3] = '{OpSubBe, 16'hffff};
    load_program();
    send_seed(16'ha5a5);
    send_seed(16'h0001);
    drain();

    // swap-add with B <= A, complement with A > B, rotations by the largest amount, 15
    plan[0] = '{OpSwapAdd, 16'h3333};
    plan[1] = '{OpNegCmp, 16'h0901};
    plan[2] = '{OpRotL, 16'h0f00};
    plan[3] = '{OpRotR, 16'h000f};
    load_program();
    send_seed(16'h1234);
    send_seed(16'hffff);
    send_seed(16'h00ff);
    drain();

    // opcodes outside the set leave the value alone
    plan[0] = '{8'hff, 16'hffff};
    plan[1] = '{8'h06, 16'h1234};
    plan[2] = '{8'h00, 16'h5555};
    plan[3] = '{OpSubLe, 16'hffff};
    load_program();
    send_seed(16'h5a5a);
    send_seed(16'hff00);
    drain();

    for (int round = 0; round < RandomRounds; round++) begin
      foreach (plan[k]) plan[k] = '{pick_op(), pick_arg()};
      if (round == 0) begin
        foreach (plan[k]) plan[k].arg = '1;
      end else if (round == 1) begin
        foreach (plan[k]) plan[k].arg = '0;
      end
      calm = (round == 5);
      load_program();
      repeat (SeedsPerRound) send_seed(pick_seed());
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk_i);
    $display("ran %0d seeds through %0d step programs, %0d keys compared, %0d errors",
             seeds_sent, programs_loaded, keys_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== seed_to_key_four_op_transform.f =====
hw/rtl/sk4_pkg.sv
hw/rtl/sk4_if.sv
hw/rtl/sk4_cfg_regs.sv
hw/rtl/sk4_cell.sv
hw/rtl/seed_to_key_four_op_transform.sv
bench/sk4_key_checker.sv
bench/testbench.sv
